### src/radio_rx_poll_and_frame_end_detect_defines.svh
// Assertion macros shared by the receive poll and frame-end detector.
`ifndef RADIO_RX_POLL_AND_FRAME_END_DETECT_DEFINES_SVH
`define RADIO_RX_POLL_AND_FRAME_END_DETECT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RRPFED_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RRPFED_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### src/rrpfed_pkg.sv
// Types and constants for the receive poll and frame-end detector.
package rrpfed_pkg;

    localparam int BUF_DEPTH_DEF = 64;
    localparam int FRAME_LEN_W   = 6;

    localparam logic [15:0] CMD_STATUS     = 16'h0000;
    localparam logic [15:0] CMD_FIFO_READ  = 16'hB000;
    localparam logic [15:0] CMD_FIFO_START = 16'hCA81;
    localparam logic [15:0] CMD_RESTART    = 16'hCA83;
    localparam logic [7:0]  STATUS_MASK    = 8'h81;
    localparam logic [7:0]  TRAILER_BYTE   = 8'hAA;
    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_MAX = '1;

    typedef struct packed {
        logic [15:0] sent_command;
        logic [7:0]  status_high;
        logic [7:0]  rx_byte;
        logic        tx_queue_empty;
    } item_t;

    typedef struct packed {
        logic                   cmd_valid;
        logic [15:0]            next_command;
        logic                   data_valid;
        logic [7:0]             data_byte;
        logic                   frame_end;
        logic [FRAME_LEN_W-1:0] frame_length;
    } result_t;

endpackage

### src/radio_rx_poll_and_frame_end_detect.sv
// Top level of the receive poll and frame-end detector for a serial-command radio.
// An accepted transfer passes the input register, the decode pass and then the result register.
// Throughput: one transaction per cycle unless the output stalls, set by that single decode pass.
// Reset (rst_n, asynchronous, active low) empties both stages and clears the trailer window
// and byte count; the result payload registers are not reset.
`include "radio_rx_poll_and_frame_end_detect_defines.svh"

module radio_rx_poll_and_frame_end_detect
    import rrpfed_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] sent_command,
    input  logic [7:0]  status_high,
    input  logic [7:0]  rx_byte,
    input  logic        tx_queue_empty,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        cmd_valid,
    output logic [15:0] next_command,
    output logic        data_valid,
    output logic [7:0]  data_byte,
    output logic        frame_end,
    output logic [FRAME_LEN_W-1:0] frame_length
);

    // The byte count saturates at BUF_DEPTH + 1, so it needs room for that value.
    localparam int CNT_W = $clog2(BUF_DEPTH + 2);

    // Input stage: holds one accepted transaction until the result register can take it.
    logic    in_valid_reg;
    item_t   item_reg;

    // Result stage.
    logic    out_valid_reg;
    result_t res_reg;

    // Receive state: three-byte trailer window (element 2 newest) and byte count.
    logic [2:0][7:0]  win_reg;
    logic [CNT_W-1:0] cnt_reg;

    result_t          res_next;
    logic             state_we;
    logic [2:0][7:0]  win_next;
    logic [CNT_W-1:0] cnt_next;

    logic out_free;
    logic advance;
    logic in_take;

    // The result register is free when it is empty or its contents leave this cycle.
    // The input stage moves forward whenever it is full and the result register is free,
    // so an empty input stage takes a new transfer even while a finished result waits downstream.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    rrpfed_decode #(
        .BUF_DEPTH (BUF_DEPTH),
        .CNT_W     (CNT_W)
    ) u_decode (
        .item     (item_reg),
        .win      (win_reg),
        .cnt      (cnt_reg),
        .res      (res_next),
        .state_we (state_we),
        .win_next (win_next),
        .cnt_next (cnt_next)
    );

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            win_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end

            // The receive state changes only as a FIFO read passes into the result register.
            if (advance && state_we)
            begin
                win_reg <= win_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= '{sent_command:   sent_command,
                          status_high:    status_high,
                          rx_byte:        rx_byte,
                          tx_queue_empty: tx_queue_empty};
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cmd_valid    = res_reg.cmd_valid;
    assign next_command = res_reg.next_command;
    assign data_valid   = res_reg.data_valid;
    assign data_byte    = res_reg.data_byte;
    assign frame_end    = res_reg.frame_end;
    assign frame_length = res_reg.frame_length;

    // A frame end is only ever reported together with the trailer byte that completed it.
    `RRPFED_ASSERT_IMP(a_frame_end_has_data, clk, rst_n, out_valid_reg && res_reg.frame_end, res_reg.data_valid && (res_reg.data_byte == TRAILER_BYTE))
    // The byte count never passes its saturation point.
    `RRPFED_ASSERT_IMP(a_count_bounded, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(BUF_DEPTH + 1))
    // A transaction that moves forward always lands in the result register.
    `RRPFED_ASSERT_NXT(a_advance_fills_out, clk, rst_n, advance, out_valid_reg)
    // The input side is held off only while both stages are occupied.
    `RRPFED_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, in_stall, in_valid_reg && out_valid_reg && out_stall)

endmodule

### src/rrpfed_decode.sv
// Command decode, trailer detection and state update for one transaction.
module rrpfed_decode
    import rrpfed_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF,
    parameter int CNT_W     = $clog2(BUF_DEPTH + 2)
)
(
    input  item_t               item,
    input  logic [2:0][7:0]     win,
    input  logic [CNT_W-1:0]    cnt,
    output result_t             res,
    output logic                state_we,
    output logic [2:0][7:0]     win_next,
    output logic [CNT_W-1:0]    cnt_next
);

    logic [CNT_W-1:0] cnt_inc;
    logic [7:0]       cnt_ext;
    logic [7:0]       len_full;
    logic             trailer_hit;

    always_comb
    begin
        // Window shifted with the new byte in the newest slot.
        win_next = {item.rx_byte, win[2], win[1]};
        cnt_inc  = (cnt <= CNT_W'(BUF_DEPTH)) ? cnt + CNT_W'(1) : cnt;
        cnt_ext  = 8'(cnt_inc);
        len_full = (cnt_ext > 8'd3) ? cnt_ext - 8'd3 : 8'd0;

        trailer_hit = (win_next[0] == TRAILER_BYTE) && (win_next[1] == TRAILER_BYTE)
                   && (win_next[2] == TRAILER_BYTE);

        res      = '0;
        state_we = 1'b0;
        cnt_next = cnt_inc;

        unique case (item.sent_command)
            CMD_STATUS:
            begin
                if ((item.status_high & STATUS_MASK) != 8'h00)
                begin
                    res.cmd_valid    = 1'b1;
                    res.next_command = CMD_FIFO_READ;
                end
            end
            CMD_FIFO_START:
            begin
                res.cmd_valid    = 1'b1;
                res.next_command = CMD_RESTART;
            end
            CMD_RESTART:
            begin
                res.cmd_valid    = 1'b1;
                res.next_command = CMD_STATUS;
            end
            CMD_FIFO_READ:
            begin
                state_we       = 1'b1;
                res.data_valid = 1'b1;
                res.data_byte  = item.rx_byte;
                if (trailer_hit)
                begin
                    res.frame_end    = 1'b1;
                    res.frame_length = (len_full > 8'(FRAME_LEN_MAX)) ? FRAME_LEN_MAX
                                                                      : len_full[FRAME_LEN_W-1:0];
                    cnt_next         = '0;
                    if (item.tx_queue_empty)
                    begin
                        res.cmd_valid    = 1'b1;
                        res.next_command = CMD_FIFO_START;
                    end
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

### test/tb_radio_rx_poll_and_frame_end_detect.sv
// Self-checking testbench for the receive poll and frame-end detector.
module tb_radio_rx_poll_and_frame_end_detect;
    import rrpfed_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The block is built with its default buffer depth, and the predictor uses the same value.
    localparam int BUF_DEPTH = BUF_DEPTH_DEF;

    // Number of random transfers that do real work. Ignored command words are not counted.
    localparam int RANDOM_ITEMS = 1200;

    // The run stops here if it has not finished. This is far above the slowest correct run.
    localparam int CYCLE_LIMIT = 200000;

    // The output side holds off for this long so that both stages fill and the input stalls.
    localparam int HOLD_START = 300;
    localparam int HOLD_LEN = 200;

    // The output side never stalls during this window of cycles.
    localparam int RX_BUSY_LO = 1000;
    localparam int RX_BUSY_HI = 1400;

    // The input side never idles while it offers these items.
    localparam int TX_BUSY_LO = 600;
    localparam int TX_BUSY_HI = 900;

    // Before it offers this item, the input side waits until every expected result has come.
    localparam int DRAIN_AT = 400;

    // After the last expected result, the run waits this many more cycles before it reports.
    localparam int TAIL_CYCLES = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] sent_command = '0;
    logic [7:0]  status_high = '0;
    logic [7:0]  rx_byte = '0;
    logic        tx_queue_empty = 1'b0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        cmd_valid;
    logic [15:0] next_command;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        frame_end;
    logic [FRAME_LEN_W-1:0] frame_length;

    // Transactions waiting to be offered, and the results expected from accepted transfers.
    item_t   pending_txn_q[$];
    result_t expected_result_q[$];

    // The predictor's copy of the block's state: the last three FIFO bytes, newest in slot 2,
    // and the saturating count of bytes since the last frame end.
    logic [7:0] trail_win[0:2];
    logic [6:0] byte_cnt;

    int sent_cnt = 0;
    int mismatch_cnt = 0;
    int cycle_cnt = 0;
    int rx_cyc = 0;

    radio_rx_poll_and_frame_end_detect #(
        .BUF_DEPTH(BUF_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sent_command(sent_command),
        .status_high(status_high),
        .rx_byte(rx_byte),
        .tx_queue_empty(tx_queue_empty),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cmd_valid(cmd_valid),
        .next_command(next_command),
        .data_valid(data_valid),
        .data_byte(data_byte),
        .frame_end(frame_end),
        .frame_length(frame_length)
    );

    always #5 clk = ~clk;

    // This computes the result of one completed transaction and advances the predictor state.
    // The command echo picks the next command. A FIFO read also shifts the byte into the
    // trailer window and checks it for the three-byte 0xAA trailer.
    function automatic result_t predict_poll_result(item_t txn);
        result_t    res;
        logic [6:0] len;
        res = '0;
        case (txn.sent_command)
            CMD_STATUS:
            begin
                // A status read with neither flag bit set gives no command.
                if ((txn.status_high & STATUS_MASK) != '0)
                begin
                    res.cmd_valid = 1'b1;
                    res.next_command = CMD_FIFO_READ;
                end
            end
            CMD_FIFO_START:
            begin
                res.cmd_valid = 1'b1;
                res.next_command = CMD_RESTART;
            end
            CMD_RESTART:
            begin
                res.cmd_valid = 1'b1;
                res.next_command = CMD_STATUS;
            end
            CMD_FIFO_READ:
            begin
                trail_win[0] = trail_win[1];
                trail_win[1] = trail_win[2];
                trail_win[2] = txn.rx_byte;
                if (byte_cnt <= BUF_DEPTH)
                begin
                    byte_cnt = byte_cnt + 7'd1;
                end
                res.data_valid = 1'b1;
                res.data_byte = txn.rx_byte;
                if (trail_win[0] == TRAILER_BYTE && trail_win[1] == TRAILER_BYTE &&
                    trail_win[2] == TRAILER_BYTE)
                begin
                    // The trailer bytes are counted too, so the length drops them, never below zero.
                    len = (byte_cnt > 7'd3) ? byte_cnt - 7'd3 : 7'd0;
                    res.frame_length = (len > FRAME_LEN_MAX) ? FRAME_LEN_MAX : len[FRAME_LEN_W-1:0];
                    res.frame_end = 1'b1;
                    byte_cnt = '0;
                    // A pending transmission keeps the radio from restarting the receive FIFO.
                    if (txn.tx_queue_empty)
                    begin
                        res.cmd_valid = 1'b1;
                        res.next_command = CMD_FIFO_START;
                    end
                end
            end
            default:
            begin
                // Any other command word is ignored and leaves the state alone.
            end
        endcase
        return res;
    endfunction

    task automatic add_txn(input logic [15:0] cmd, input logic [7:0] stat,
                           input logic [7:0] rxb, input logic txe);
        pending_txn_q.push_back('{cmd, stat, rxb, txe});
    endtask

    // Input driver. It predicts the result of every accepted transfer at the edge that accepts
    // it, then either holds the stalled payload, offers the next pending transaction, or idles.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        item_t nxt;
        logic  hold_off;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sent_command <= '0;
            status_high <= '0;
            rx_byte <= '0;
            tx_queue_empty <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_result_q.push_back(
                    predict_poll_result('{sent_command, status_high, rx_byte, tx_queue_empty}));
            end
            if (!in_valid || !in_stall)
            begin
                hold_off = 1'b0;
                if (!(sent_cnt >= TX_BUSY_LO && sent_cnt < TX_BUSY_HI) &&
                    $urandom_range(0, 99) < 26)
                begin
                    hold_off = 1'b1;
                end
                // Let the pipeline drain completely once before going on.
                if (sent_cnt == DRAIN_AT && expected_result_q.size() != 0)
                begin
                    hold_off = 1'b1;
                end
                if (pending_txn_q.size() != 0 && !hold_off)
                begin
                    nxt = pending_txn_q.pop_front();
                    in_valid <= 1'b1;
                    sent_command <= nxt.sent_command;
                    status_high <= nxt.status_high;
                    rx_byte <= nxt.rx_byte;
                    tx_queue_empty <= nxt.tx_queue_empty;
                    sent_cnt <= sent_cnt + 1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side. It stalls at random, not at all during one window, and for one long
    // stretch early on so that the block backs up into its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_cyc <= 0;
        end
        else
        begin
            rx_cyc <= rx_cyc + 1;
            if (rx_cyc >= HOLD_START && rx_cyc < HOLD_START + HOLD_LEN)
            begin
                out_stall <= 1'b1;
            end
            else if (rx_cyc >= RX_BUSY_LO && rx_cyc < RX_BUSY_HI)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < 26);
            end
        end
    end

    // Result monitor. Every output transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin : check_proc
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{cmd_valid, next_command, data_valid, data_byte, frame_end, frame_length};
            if (expected_result_q.size() == 0)
            begin
                if (mismatch_cnt < 10)
                begin
                    $display("%0t: result with nothing expected: cmd %0b/%h data %0b/%h end %0b/%0d",
                             $realtime, got.cmd_valid, got.next_command, got.data_valid,
                             got.data_byte, got.frame_end, got.frame_length);
                end
                mismatch_cnt <= mismatch_cnt + 1;
            end
            else
            begin
                want = expected_result_q.pop_front();
                if (got.cmd_valid !== want.cmd_valid || got.next_command !== want.next_command ||
                    got.data_valid !== want.data_valid || got.data_byte !== want.data_byte ||
                    got.frame_end !== want.frame_end || got.frame_length !== want.frame_length)
                begin
                    if (mismatch_cnt < 10)
                    begin
                        $display("%0t: mismatch: expected cmd %0b/%h data %0b/%h end %0b/%0d",
                                 $realtime, want.cmd_valid, want.next_command, want.data_valid,
                                 want.data_byte, want.frame_end, want.frame_length);
                        $display("%0t:           actual   cmd %0b/%h data %0b/%h end %0b/%0d",
                                 $realtime, got.cmd_valid, got.next_command, got.data_valid,
                                 got.data_byte, got.frame_end, got.frame_length);
                    end
                    mismatch_cnt <= mismatch_cnt + 1;
                end
            end
        end
    end

    // Watchdog. A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb_radio_rx_poll_and_frame_end_detect: errors");
            $finish;
        end
    end

    initial
    begin : stim_proc
        int    work_cnt;
        int    n_bytes;
        int    pick;
        logic [7:0] b;
        logic [15:0] cmd;

        trail_win[0] = '0;
        trail_win[1] = '0;
        trail_win[2] = '0;
        byte_cnt = '0;

        // Directed part. The status flags one at a time, both echoes, ignored command words,
        // the extreme byte values, and frame ends with an empty and a busy transmit queue.
        add_txn(CMD_STATUS, 8'h00, 8'h00, 1'b0);
        add_txn(CMD_STATUS, 8'h80, 8'h00, 1'b0);
        add_txn(CMD_STATUS, 8'h01, 8'h00, 1'b1);
        add_txn(CMD_STATUS, 8'hFF, 8'hFF, 1'b1);
        add_txn(CMD_STATUS, 8'h7E, 8'hFF, 1'b0);
        add_txn(CMD_FIFO_START, 8'h00, 8'h00, 1'b1);
        add_txn(CMD_RESTART, 8'hFF, 8'hFF, 1'b0);
        add_txn(16'hFFFF, 8'hFF, 8'hFF, 1'b1);
        add_txn(16'h0001, 8'h81, 8'hAA, 1'b1);
        add_txn(CMD_FIFO_READ, 8'h00, 8'h00, 1'b1);
        add_txn(CMD_FIFO_READ, 8'hFF, 8'hFF, 1'b0);
        add_txn(CMD_FIFO_READ, 8'h00, TRAILER_BYTE, 1'b1);
        add_txn(CMD_FIFO_READ, 8'h00, TRAILER_BYTE, 1'b1);
        add_txn(CMD_FIFO_READ, 8'h00, TRAILER_BYTE, 1'b1);
        // The window still holds the trailer, so one more 0xAA ends a frame of length zero.
        add_txn(CMD_FIFO_READ, 8'h00, TRAILER_BYTE, 1'b0);
        add_txn(CMD_FIFO_READ, 8'h00, 8'h55, 1'b0);
        add_txn(CMD_FIFO_READ, 8'h00, TRAILER_BYTE, 1'b0);
        add_txn(CMD_FIFO_READ, 8'h00, TRAILER_BYTE, 1'b0);
        add_txn(CMD_FIFO_READ, 8'h00, TRAILER_BYTE, 1'b0);
        add_txn(CMD_FIFO_READ, 8'hFF, 8'hAB, 1'b1);
        add_txn(CMD_STATUS, 8'h00, 8'hFF, 1'b1);

        // Random part. Most of it is the normal receive loop: a status poll with a flag set,
        // then a FIFO read, byte after byte, closed by the trailer and the FIFO restart echoes.
        // Now and then a frame is long enough to saturate the byte count.
        work_cnt = 0;
        while (work_cnt < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                n_bytes = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 72)
                                                       : $urandom_range(0, 12);
                for (int i = 0; i < n_bytes + 3; i++)
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        // The radio has nothing yet: a poll with no flag set.
                        add_txn(CMD_STATUS, 8'($urandom()) & ~STATUS_MASK, 8'($urandom()),
                                1'($urandom_range(0, 1)));
                        work_cnt++;
                    end
                    add_txn(CMD_STATUS,
                            8'($urandom()) | ($urandom_range(0, 1) ? 8'h80 : 8'h01),
                            8'($urandom()), 1'($urandom_range(0, 1)));
                    b = (i >= n_bytes || $urandom_range(0, 7) == 0) ? TRAILER_BYTE
                                                                     : 8'($urandom());
                    add_txn(CMD_FIFO_READ, 8'($urandom()), b, 1'($urandom_range(0, 1)));
                    work_cnt += 2;
                end
                add_txn(CMD_FIFO_START, 8'($urandom()), 8'($urandom()),
                        1'($urandom_range(0, 1)));
                add_txn(CMD_RESTART, 8'($urandom()), 8'($urandom()),
                        1'($urandom_range(0, 1)));
                work_cnt += 2;
            end
            else if (pick < 85)
            begin
                case ($urandom_range(0, 3))
                    0: cmd = CMD_STATUS;
                    1: cmd = CMD_FIFO_READ;
                    2: cmd = CMD_FIFO_START;
                    default: cmd = CMD_RESTART;
                endcase
                add_txn(cmd, 8'($urandom()), 8'($urandom()), 1'($urandom_range(0, 1)));
                work_cnt++;
            end
            else
            begin
                // Noise: a random command word, mostly one the block ignores.
                cmd = 16'($urandom());
                add_txn(cmd, 8'($urandom()), 8'($urandom()), 1'($urandom_range(0, 1)));
                if (cmd == CMD_STATUS || cmd == CMD_FIFO_READ || cmd == CMD_FIFO_START ||
                    cmd == CMD_RESTART)
                begin
                    work_cnt++;
                end
            end
        end

        // Reset is held at the start and released once.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every transaction has been accepted, then until every result has come.
        while (pending_txn_q.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (expected_result_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && expected_result_q.size() == 0)
        begin
            $display("tb_radio_rx_poll_and_frame_end_detect: clean");
        end
        else
        begin
            $display("tb_radio_rx_poll_and_frame_end_detect: errors");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/rrpfed_pkg.sv
src/rrpfed_decode.sv
src/radio_rx_poll_and_frame_end_detect.sv
test/tb_radio_rx_poll_and_frame_end_detect.sv
